### sv/mlfq_pkg.sv
// mlfq_pkg: shared types and constants for the multilevel feedback queue
// used by mlfq_ctrl, mlfq_dp and multilevel_feedback_queue_top
package mlfq_pkg;
    localparam int NumLevels   = 4;
    localparam int PoolEntries = 64;
    localparam int LvW         = $clog2(NumLevels);
    localparam int PtrW        = $clog2(PoolEntries);
    localparam int CntW        = $clog2(PoolEntries + 1);
    localparam int IdW         = 6;
    localparam int TickW       = 16;
    localparam logic [TickW-1:0] ThresholdReset = TickW'(40 + 10);

    localparam logic [1:0] OpInsert  = 2'd0;
    localparam logic [1:0] OpPop     = 2'd1;
    localparam logic [1:0] OpPromote = 2'd2;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StEmpty = 2'd1;
    localparam logic [1:0] StRange = 2'd2;
    localparam logic [1:0] StFull  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item
        logic exec;     // perform the item's update with memory read data
        logic splice;   // splice one lower level onto level 0
        logic [LvW-1:0] splice_lv;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       promote;   // tick at or above threshold
        logic [NumLevels-1:0] nonempty;
    } t_stat;
endpackage

### sv/mlfq_dp.sv
// mlfq_dp: node pool memories, level head/tail registers and result register
// depends on mlfq_pkg
module mlfq_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mlfq_pkg::t_cmd         i_cmd,
    output mlfq_pkg::t_stat        o_stat,
    input  logic [1:0]             i_opcode,
    input  logic [mlfq_pkg::IdW-1:0]   i_pid,
    input  logic [2:0]             i_level,
    input  logic [mlfq_pkg::TickW-1:0] i_ticks,
    input  logic                   i_cfg_we,
    input  logic [mlfq_pkg::TickW-1:0] i_cfg_data,
    output logic [10:0]            o_result
);
    import mlfq_pkg::*;

    logic [IdW-1:0]  r_id_mem [PoolEntries];
    logic [PtrW-1:0] r_next_mem [PoolEntries];
    logic [PoolEntries-1:0] r_next_valid;   // invalid entry reads as i+1
    logic [PtrW-1:0] r_head [NumLevels];
    logic [PtrW-1:0] r_tail [NumLevels];
    logic [NumLevels-1:0] r_nonempty;
    logic [PtrW-1:0] r_free_head;
    logic [CntW-1:0] r_free_cnt;
    logic [TickW-1:0] r_thresh;
    logic [1:0] r_op;
    logic [IdW-1:0] r_pid;
    logic [2:0] r_lv;
    logic r_promote;
    logic [10:0] r_result;
    logic [10:0] n_result;

    // pop target: lowest-numbered nonempty level (level 0 first)
    logic [LvW-1:0] pop_lv;
    logic pop_any;
    always_comb begin
        pop_lv = '0;
        pop_any = 1'b0;
        for (int q = NumLevels - 1; q >= 0; q--) begin
            if (r_nonempty[q]) begin
                pop_lv = LvW'(q);
                pop_any = 1'b1;
            end
        end
    end

    // registered memory reads, addressed at load time
    logic [PtrW-1:0] r_rd_next;
    logic            r_rd_nv;
    logic [IdW-1:0]  r_rd_id;
    logic [PtrW-1:0] rd_addr;
    always_comb begin
        rd_addr = r_free_head;
        if (i_opcode == OpPop) rd_addr = r_head[pop_lv];
    end
    always_ff @(posedge i_clk) begin
        r_rd_next <= r_next_mem[rd_addr];
        r_rd_nv   <= r_next_valid[rd_addr];
        r_rd_id   <= r_id_mem[rd_addr];
    end
    logic [PtrW-1:0] rd_next;
    logic [PtrW-1:0] rd_addr_q;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) rd_addr_q <= rd_addr;
    end
    assign rd_next = r_rd_nv ? r_rd_next : PtrW'(rd_addr_q + 1'b1);

    logic lv_ok;
    logic [LvW-1:0] ins_lv;
    assign lv_ok  = (r_lv < 3'(NumLevels));
    assign ins_lv = r_lv[LvW-1:0];

    // single write port on next-pointer memory
    logic we_next;
    logic [PtrW-1:0] wa_next, wd_next;
    logic we_id;
    always_comb begin
        we_next = 1'b0;
        wa_next = '0;
        wd_next = '0;
        we_id = 1'b0;
        if (i_cmd.exec && r_op == OpInsert && lv_ok && r_free_cnt != '0) begin
            we_id = 1'b1;
            if (r_nonempty[ins_lv]) begin
                we_next = 1'b1;
                wa_next = r_tail[ins_lv];
                wd_next = rd_addr_q;
            end
        end else if (i_cmd.exec && r_op == OpPop && pop_any) begin
            we_next = 1'b1;
            wa_next = rd_addr_q;
            wd_next = r_free_head;
        end else if (i_cmd.splice && r_nonempty[i_cmd.splice_lv] && r_nonempty[0]) begin
            we_next = 1'b1;
            wa_next = r_tail[0];
            wd_next = r_head[i_cmd.splice_lv];
        end
    end

    // result of the item being executed
    always_comb begin
        n_result = '0;
        case (r_op)
            OpInsert: begin
                if (!lv_ok) n_result[1:0] = StRange;
                else if (r_free_cnt == '0) n_result[1:0] = StFull;
            end
            OpPop: begin
                if (!pop_any) begin
                    n_result[1:0] = StEmpty;
                end else begin
                    n_result[7:2] = r_rd_id;
                    n_result[9:8] = 2'(pop_lv);
                end
            end
            OpPromote: n_result[10] = r_promote;
            default: n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_next) r_next_mem[wa_next] <= wd_next;
        if (we_id) r_id_mem[rd_addr_q] <= r_pid;
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_pid <= i_pid;
            r_lv  <= i_level;
            r_promote <= (i_ticks >= r_thresh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_valid <= '0;
            r_nonempty <= '0;
            r_free_head <= '0;
            r_free_cnt <= CntW'(PoolEntries);
            r_thresh <= ThresholdReset;
            r_result <= '0;
            for (int q = 0; q < NumLevels; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
            end
        end else begin
            if (i_cfg_we) r_thresh <= i_cfg_data;
            if (we_next) r_next_valid[wa_next] <= 1'b1;
            if (i_cmd.exec) begin
                r_result <= n_result;
                case (r_op)
                    OpInsert: begin
                        if (lv_ok && r_free_cnt != '0) begin
                            r_free_head <= rd_next;
                            r_free_cnt <= r_free_cnt - 1'b1;
                            // node's own next is don't-care while it is the tail
                            if (!r_nonempty[ins_lv]) r_head[ins_lv] <= rd_addr_q;
                            r_nonempty[ins_lv] <= 1'b1;
                            r_tail[ins_lv] <= rd_addr_q;
                        end
                    end
                    OpPop: begin
                        if (pop_any) begin
                            if (rd_addr_q == r_tail[pop_lv]) r_nonempty[pop_lv] <= 1'b0;
                            else r_head[pop_lv] <= rd_next;
                            r_free_head <= rd_addr_q;
                            r_free_cnt <= r_free_cnt + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.splice && r_nonempty[i_cmd.splice_lv]) begin
                if (!r_nonempty[0]) r_head[0] <= r_head[i_cmd.splice_lv];
                r_nonempty[0] <= 1'b1;
                r_nonempty[i_cmd.splice_lv] <= 1'b0;
                r_tail[0] <= r_tail[i_cmd.splice_lv];
            end
        end
    end

    assign o_stat.opcode = r_op;
    assign o_stat.promote = r_promote;
    assign o_stat.nonempty = r_nonempty;
    assign o_result = r_result;
endmodule

### sv/mlfq_ctrl.sv
// mlfq_ctrl: sequencer for load, execute, splice steps and result handshake
// depends on mlfq_pkg
module mlfq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mlfq_pkg::t_cmd  o_cmd,
    input  mlfq_pkg::t_stat i_stat
);
    import mlfq_pkg::*;

    localparam logic [1:0] SIdle   = 2'd0;
    localparam logic [1:0] SExec   = 2'd1;
    localparam logic [1:0] SSplice = 2'd2;

    logic [1:0] r_state, n_state;
    logic [LvW-1:0] r_lv, n_lv;
    logic r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_lv = r_lv;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        o_cmd.splice_lv = r_lv;
        o_in_ready = 1'b0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            SIdle: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = SExec;
                end
            end
            SExec: begin
                o_cmd.exec = 1'b1;
                if (i_stat.opcode == OpPromote && i_stat.promote) begin
                    n_state = SSplice;
                    n_lv = LvW'(NumLevels - 1);
                end else begin
                    n_state = SIdle;
                    n_out_valid = 1'b1;
                end
            end
            SSplice: begin
                o_cmd.splice = 1'b1;
                n_lv = r_lv - 1'b1;
                if (r_lv == LvW'(1)) begin
                    n_state = SIdle;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_lv <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lv <= n_lv;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

### sv/multilevel_feedback_queue_top.sv
// multilevel_feedback_queue_top: four-level process queue with priority boost
// depends on mlfq_pkg, mlfq_ctrl, mlfq_dp
//
// usage
//   s_axis carries one command per transfer: tdata = opcode[1:0], process_id
//   [7:2], level[10:8], tick_count[26:11]. m_axis returns one result per
//   command: tdata = status[1:0], popped_id[7:2], popped_level[9:8],
//   ticks_cleared[10].
//   i_cfg_we/i_cfg_data write the 16-bit promotion threshold (reset 50).
//   sequence: insert, pop and a promotion below threshold go from the input
//   transfer through the registered pool read and then the update before the
//   earliest result transfer; a promotion that fires adds one splice step per
//   lower level through the shared level-0 tail update.
//   a new command is accepted only while idle, and only in the cycle the
//   waiting result transfers (or when none waits), so the block takes no new
//   command before it is through with the last one.
//   reset clears all levels, rebuilds the free chain through per-entry
//   valid bits (no clearing pass) and restores the threshold.
//   if the receiver stalls, the result holds and no command enters until
//   that result transfers.
module multilevel_feedback_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // opcode, process_id, level, tick_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status, popped_id, popped_level, ticks_cleared
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import mlfq_pkg::*;

    t_cmd cmd;
    t_stat stat;
    logic [10:0] result;

    // controller
    mlfq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_stat(stat)
    );

    // pool and level state
    mlfq_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat),
        .i_opcode(s_axis_tdata[1:0]), .i_pid(s_axis_tdata[7:2]),
        .i_level(s_axis_tdata[10:8]), .i_ticks(s_axis_tdata[26:11]),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_result(result)
    );

    assign m_axis_tdata = {5'd0, result};
endmodule

### tb/sv/mlfq_checker.sv
// mlfq_checker: watches the command and result streams of the process queue,
// predicts each result and compares; depends on mlfq_pkg
`timescale 1ns / 100ps

module mlfq_checker
    import mlfq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    typedef struct packed {
        logic [1:0]     status;
        logic [IdW-1:0] pid;
        logic [LvW-1:0] lv;
        logic           cleared;
    } t_result;

    logic [TickW-1:0] threshold;
    logic [IdW-1:0]   pid_q[NumLevels][$];
    t_result          result_q[$];

    function automatic t_result run_queue_cmd(logic [31:0] d);
        t_result r;
        logic [1:0] op;
        logic [2:0] lv;
        int total;
        r = '0;
        op = d[1:0];
        lv = d[10:8];
        total = 0;
        for (int q = 0; q < NumLevels; q++) total += pid_q[q].size();
        if (op == OpInsert) begin
            if (lv >= NumLevels) r.status = StRange;
            else if (total >= PoolEntries) r.status = StFull;
            else pid_q[lv].push_back(d[7:2]);
        end else if (op == OpPop) begin
            r.status = StEmpty;
            for (int q = 0; q < NumLevels; q++) begin
                if (r.status == StEmpty && pid_q[q].size() > 0) begin
                    r.status = StOk;
                    r.pid = pid_q[q].pop_front();
                    r.lv = LvW'(q);
                end
            end
        end else if (op == OpPromote) begin
            if (d[26:11] >= threshold) begin
                for (int q = NumLevels - 1; q >= 1; q--)
                    while (pid_q[q].size() > 0) pid_q[0].push_back(pid_q[q].pop_front());
                r.cleared = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            threshold <= ThresholdReset;
            for (int q = 0; q < NumLevels; q++) pid_q[q].delete();
            result_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_we) threshold <= i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[1:0], m_axis_tdata[7:2], m_axis_tdata[9:8],
                        m_axis_tdata[10]};
                o_result_count <= o_result_count + 1;
                if (result_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (got != want) begin
                        if (got.status != want.status)
                            $error("status: expected %0d, got %0d", want.status, got.status);
                        if (got.pid != want.pid)
                            $error("popped_id: expected %0d, got %0d", want.pid, got.pid);
                        if (got.lv != want.lv)
                            $error("popped_level: expected %0d, got %0d", want.lv, got.lv);
                        if (got.cleared != want.cleared)
                            $error("ticks_cleared: expected %0d, got %0d",
                                   want.cleared, got.cleared);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) result_q.push_back(run_queue_cmd(s_axis_tdata));
        end
    end

    assign o_pending = result_q.size();
endmodule

### tb/sv/tb.sv
// tb: stimulus and verdict for multilevel_feedback_queue_top
// depends on mlfq_pkg, the block's rtl and mlfq_checker
`timescale 1ns / 100ps

module tb;
    import mlfq_pkg::*;

    localparam int CycleLimit = 400000;
    localparam logic [1:0] OpUnused = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // opcode, process_id, level, tick_count
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // status, popped_id, popped_level, ticks_cleared
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    int fail_count, pending, result_count;
    int send_idle_pct = 0;   // sender gap chance per cycle, percent
    int recv_idle_pct = 0;   // receiver stall chance per cycle, percent
    bit hold_off = 1'b0;     // long receiver stall to fill the block
    int cmd_count = 0;
    int cycles = 0;

    always #2 i_clk = ~i_clk;

    multilevel_feedback_queue_top dut (.*);

    mlfq_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // receiver: random stalls at the falling edge, or a held-off stretch
    always @(negedge i_clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one command; wait for its transfer
    task automatic send_cmd(logic [1:0] op, logic [5:0] pid, logic [2:0] lv,
                            logic [15:0] ticks);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, ticks, lv, pid, op};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        cmd_count++;
    endtask

    // stop offering, wait until every result is back, then let the block settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed traffic: inserts outnumbering pops, occasional
    // bad levels, unused opcode and promotion checks around the threshold
    task automatic random_cmds(int n, logic [15:0] thr, int insert_pct);
        int pick;
        logic [15:0] ticks;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            ticks = $urandom_range(1) ? 16'($urandom) : 16'(thr + $urandom_range(2) - 1);
            if (pick < insert_pct)
                send_cmd(OpInsert, 6'($urandom), 3'($urandom_range(3)), 16'($urandom));
            else if (pick < insert_pct + 4)
                send_cmd(OpInsert, 6'($urandom), 3'($urandom_range(7, 4)), 16'($urandom));
            else if (pick < 88)
                send_cmd(OpPop, 6'($urandom), 3'($urandom), 16'($urandom));
            else if (pick < 97)
                send_cmd(OpPromote, 6'($urandom), 3'($urandom), ticks);
            else
                send_cmd(OpUnused, 6'($urandom), 3'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty pop, every level, bad levels, promotion at the edge
        send_cmd(OpPop, 6'd0, 3'd0, 16'd0);
        send_cmd(OpInsert, 6'd63, 3'd3, 16'hffff);
        send_cmd(OpInsert, 6'd0, 3'd2, 16'd0);
        send_cmd(OpInsert, 6'h2a, 3'd1, 16'd0);
        send_cmd(OpInsert, 6'h15, 3'd0, 16'd0);
        send_cmd(OpInsert, 6'd5, 3'd4, 16'd0);
        send_cmd(OpInsert, 6'd6, 3'd7, 16'd0);
        send_cmd(OpPromote, 6'd0, 3'd0, 16'd49);
        send_cmd(OpPromote, 6'h3f, 3'd7, 16'd50);
        send_cmd(OpUnused, 6'h3f, 3'd7, 16'hffff);
        repeat (5) send_cmd(OpPop, 6'd0, 3'd0, 16'd0);
        // fill the pool past full, then drain it
        for (int i = 0; i < 65; i++) send_cmd(OpInsert, 6'(i), 3'(i % 4), 16'd0);
        send_cmd(OpPromote, 6'd0, 3'd0, 16'hffff);
        for (int i = 0; i < 65; i++) send_cmd(OpPop, 6'd0, 3'd0, 16'd0);

        write_threshold(16'd0);
        send_idle_pct = 10;
        recv_idle_pct = 83;
        random_cmds(400, 16'd0, 50);

        write_threshold(16'hffff);
        send_idle_pct = 83;
        recv_idle_pct = 10;
        random_cmds(400, 16'hffff, 55);

        // long receiver hold-off while commands keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_cmds(40, 16'd1000, 50);
        join

        write_threshold(16'($urandom_range(200)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_cmds(700, 16'd100, 52);

        drain();
        $display("covered %0d commands, %0d results: all levels, full pool, empty pops,",
                 cmd_count, result_count);
        $display("bad levels and promotions at thresholds 0, 65535 and mid values");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### multilevel_feedback_queue_top.f
sv/mlfq_pkg.sv
sv/mlfq_dp.sv
sv/mlfq_ctrl.sv
sv/multilevel_feedback_queue_top.sv
tb/sv/mlfq_checker.sv
tb/sv/tb.sv
